// File: hw/rtl/see_pkg.sv
// shared types and constants for the sample entropy engine
`default_nettype none
package see_pkg;

    localparam int MAX_SAMPLES = 4096;
    localparam int MAX_DIM     = 8;

    localparam int SAMPLE_W = 16;
    localparam int ADDR_W   = $clog2(MAX_SAMPLES);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int DIM_W    = $clog2(MAX_DIM + 1);
    localparam int SUM_W    = SAMPLE_W + ADDR_W;
    localparam int SQ_W     = 31;
    localparam int Q_W      = SQ_W + ADDR_W;
    localparam int Q_LO_W   = 22;
    localparam int V_W      = Q_W + CNT_W;
    localparam int MUL_W    = 32;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int DIV_W    = 64;
    localparam int ITC_W    = 6;
    localparam int RAD_W    = 48;
    localparam int ROOT_W   = RAD_W / 2;
    localparam int THR_W    = 32;
    localparam int COUNT_W  = 23;
    localparam int LOG_W    = 32;
    localparam int LOG_E_W  = 5;
    localparam int LOG_F_W  = 16;
    localparam int L2_W     = LOG_E_W + LOG_F_W;
    localparam int ENT_W    = 16;
    localparam int TOL_W    = 8;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [29:0] LN2_Q30 = 30'd744261118;
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(2);
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(51);

    localparam logic [CFG_IDX_W-1:0] REG_EMBED_DIM  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOL_FACTOR = 1'd1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } see_in_t;

    typedef struct packed {
        logic [COUNT_W-1:0] match_count_next;
        logic [COUNT_W-1:0] match_count_base;
        logic [ENT_W-1:0]   entropy;
        logic               degenerate;
        logic               too_short;
    } see_out_t;

endpackage
`default_nettype wire

// File: hw/rtl/see_ram.sv
// generic ram, one write port and two registered read ports
`default_nettype none
module see_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output      logic [WIDTH-1:0]         rd_data_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output      logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule
`default_nettype wire

// File: hw/rtl/sample_entropy_engine.sv
// sample entropy engine top level: loader, statistics, pair matching and log sequencer
//
//   channel   dir   handshake                  payload
//   sample    in    sample_valid/sample_stall  see_in_t  (sample, last)
//   result    out   result_valid/result_stall  see_out_t (counts, entropy, flags)
//   cfg       in    cfg_we                     cfg_index, cfg_data
//
// samples load at one beat per cycle into the sample ram
// after the last beat: statistics (64-step divider run twice,
//   24-step square root), then the pair loop (read state S_MRD, compare state S_MCMP),
//   then up to two log2 runs on the shared multiplier
// reset clears control state; the sample ram is not cleared and needs no sweep
// sample_stall is high from the last beat until the result is loaded into the
//   output register; a stalled result still lets the next series load
`default_nettype none
module sample_entropy_engine (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        sample_valid,
    output      logic                        sample_stall,
    input  wire see_pkg::see_in_t            sample_data,
    output      logic                        result_valid,
    input  wire logic                        result_stall,
    output      see_pkg::see_out_t           result_data,
    input  wire logic                        cfg_we,
    input  wire logic [see_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [see_pkg::CFG_W-1:0]   cfg_data
);

    localparam int AW  = see_pkg::ADDR_W;
    localparam int CW  = see_pkg::CNT_W;
    localparam int DW  = see_pkg::DIM_W;
    localparam int MW  = see_pkg::MUL_W;
    localparam int DVW = see_pkg::DIV_W;
    localparam int RW  = see_pkg::RAD_W;
    localparam int LW  = see_pkg::LOG_W;
    localparam int L2W = see_pkg::L2_W;

    localparam logic [4:0] S_LOAD   = 5'd0;
    localparam logic [4:0] S_SQWAIT = 5'd1;
    localparam logic [4:0] S_MUL0   = 5'd2;
    localparam logic [4:0] S_MUL1   = 5'd3;
    localparam logic [4:0] S_MUL2   = 5'd4;
    localparam logic [4:0] S_MUL3   = 5'd5;
    localparam logic [4:0] S_DIV1   = 5'd6;
    localparam logic [4:0] S_DIV2   = 5'd7;
    localparam logic [4:0] S_SQRT   = 5'd8;
    localparam logic [4:0] S_THR0   = 5'd9;
    localparam logic [4:0] S_THR1   = 5'd10;
    localparam logic [4:0] S_MRD    = 5'd11;
    localparam logic [4:0] S_MCMP   = 5'd12;
    localparam logic [4:0] S_LSEL   = 5'd13;
    localparam logic [4:0] S_LDEG   = 5'd14;
    localparam logic [4:0] S_LNORM  = 5'd15;
    localparam logic [4:0] S_LSQ0   = 5'd16;
    localparam logic [4:0] S_LSQ1   = 5'd17;
    localparam logic [4:0] S_LDONE  = 5'd18;
    localparam logic [4:0] S_LN0    = 5'd19;
    localparam logic [4:0] S_LN1    = 5'd20;
    localparam logic [4:0] S_OUT    = 5'd21;

    localparam logic [see_pkg::ITC_W-1:0] DIV_LAST  = see_pkg::ITC_W'(DVW - 1);
    localparam logic [see_pkg::ITC_W-1:0] SQRT_LAST = see_pkg::ITC_W'(see_pkg::ROOT_W - 1);
    localparam logic [see_pkg::ITC_W-1:0] LSQ_LAST  = see_pkg::ITC_W'(see_pkg::LOG_F_W - 1);

    // control and configuration
    logic [4:0]                     state_reg, state_next;
    logic [DW-1:0]                  embed_reg, embed_next;
    logic [see_pkg::TOL_W-1:0]      tol_reg, tol_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic signed [see_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [see_pkg::SQ_W-1:0]       sq_reg, sq_next;
    logic                           sq_pend_reg, sq_pend_next;
    logic [see_pkg::Q_W-1:0]        q_reg, q_next;
    logic [DW-1:0]                  m_reg, m_next;
    logic [CW-1:0]                  nm_reg, nm_next;
    logic [see_pkg::ITC_W-1:0]      itc_reg, itc_next;

    // statistics datapath
    logic [see_pkg::PROD_W-1:0]     prod_reg;
    logic [MW-1:0]                  mul_a, mul_b;
    logic [see_pkg::V_W-1:0]        acc_reg, acc_next;
    logic [DVW-1:0]                 quo_reg, quo_next;
    logic [CW-1:0]                  rem_reg, rem_next;
    logic [RW-1:0]                  rad_reg, rad_next;
    logic [RW-1:0]                  root_reg, root_next;
    logic [RW-1:0]                  sqbit_reg, sqbit_next;
    logic [see_pkg::THR_W-1:0]      thr_reg, thr_next;

    // matching
    logic [AW-1:0]                  i_reg, i_next;
    logic [AW-1:0]                  j_reg, j_next;
    logic [DW-1:0]                  k_reg, k_next;
    logic [see_pkg::COUNT_W-1:0]    cnt_a_reg, cnt_a_next;
    logic [see_pkg::COUNT_W-1:0]    cnt_b_reg, cnt_b_next;
    logic                           degen_reg, degen_next;
    logic                           short_reg, short_next;

    // log2 and ln
    logic [LW-1:0]                  log_x_reg, log_x_next;
    logic [see_pkg::LOG_E_W-1:0]    log_e_reg, log_e_next;
    logic [LW-2:0]                  log_y_reg, log_y_next;
    logic [see_pkg::LOG_F_W-1:0]    frac_reg, frac_next;
    logic                           pass_reg, pass_next;
    logic [L2W-1:0]                 lb_reg, lb_next;
    logic [L2W-1:0]                 diff_reg, diff_next;
    logic [see_pkg::ENT_W-1:0]      ent_reg, ent_next;

    // output register
    logic                           out_valid_reg, out_valid_next;
    see_pkg::see_out_t              out_data_reg, out_data_next;

    // ram
    logic                           ram_we;
    logic [AW-1:0]                  rd_addr_a, rd_addr_b;
    logic [see_pkg::SAMPLE_W-1:0]   rd_data_a, rd_data_b;

    logic                           in_beat;
    logic                           store_ok;
    logic signed [2*see_pkg::SAMPLE_W-1:0] sq_full;
    logic [see_pkg::SUM_W-1:0]      sum_abs;

    // divider step
    logic [CW:0]                    div_r, div_sub;
    logic                           div_ge;
    logic [CW-1:0]                  rem_step;
    logic [DVW-1:0]                 quo_step;

    // root step
    logic [RW-1:0]                  root_sum;
    logic                           root_ge;
    logic [RW-1:0]                  root_step;

    // compare
    logic signed [see_pkg::SAMPLE_W:0] diff_s;
    logic [see_pkg::SAMPLE_W:0]     diff_abs;
    logic                           sample_match;

    logic [31:0]                    sq_t;
    logic [51:0]                    ln_sum;
    logic [L2W-1:0]                 l2_val;
    logic [DW-1:0]                  m_clamp;

    assign in_beat  = sample_valid && !sample_stall;
    assign store_ok = count_reg < CW'(see_pkg::MAX_SAMPLES);
    assign ram_we   = in_beat && store_ok;
    assign sq_full  = sample_data.sample * sample_data.sample;
    assign sum_abs  = sum_reg[see_pkg::SUM_W-1] ? see_pkg::SUM_W'(-sum_reg)
                                                  : see_pkg::SUM_W'(sum_reg);

    assign sample_stall = (state_reg != S_LOAD);
    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

    assign rd_addr_a = i_reg + AW'(k_reg);
    assign rd_addr_b = j_reg + AW'(k_reg);

    see_ram #(
        .WIDTH (see_pkg::SAMPLE_W),
        .DEPTH (see_pkg::MAX_SAMPLES)
    ) u_store (
        .clk       (clk),
        .wr_en     (ram_we),
        .wr_addr   (count_reg[AW-1:0]),
        .wr_data   (sample_data.sample),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_data_b)
    );

    // restoring divider, one quotient bit a cycle, divisor is the series length
    assign div_r    = {rem_reg, quo_reg[DVW-1]};
    assign div_ge   = div_r >= {1'b0, count_reg};
    assign div_sub  = div_r - {1'b0, count_reg};
    assign rem_step = div_ge ? div_sub[CW-1:0] : div_r[CW-1:0];
    assign quo_step = {quo_reg[DVW-2:0], div_ge};

    // bit-pair square root step
    assign root_sum  = root_reg + sqbit_reg;
    assign root_ge   = rad_reg >= root_sum;
    assign root_step = root_ge ? (root_reg >> 1) + sqbit_reg : root_reg >> 1;

    // tolerance test: |a-b| * 65536 <= thr
    assign diff_s       = $signed({rd_data_a[see_pkg::SAMPLE_W-1], rd_data_a})
                        - $signed({rd_data_b[see_pkg::SAMPLE_W-1], rd_data_b});
    assign diff_abs     = diff_s[see_pkg::SAMPLE_W] ? (see_pkg::SAMPLE_W+1)'(-diff_s)
                                                    : (see_pkg::SAMPLE_W+1)'(diff_s);
    assign sample_match = {diff_abs, 16'b0} <= {1'b0, thr_reg};

    assign sq_t   = prod_reg[61:30];
    assign ln_sum = prod_reg[51:0] + (52'd1 << 34);
    assign l2_val = {log_e_reg, frac_reg};

    assign m_clamp = (embed_reg == '0) ? DW'(1)
                   : (embed_reg > DW'(see_pkg::MAX_DIM)) ? DW'(see_pkg::MAX_DIM)
                   : embed_reg;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MUL0:
            begin
                mul_a = MW'(count_reg);
                mul_b = MW'(q_reg[see_pkg::Q_LO_W-1:0]);
            end
            S_MUL1:
            begin
                mul_a = MW'(count_reg);
                mul_b = MW'(q_reg[see_pkg::Q_W-1:see_pkg::Q_LO_W]);
            end
            S_MUL2:
            begin
                mul_a = MW'(sum_abs);
                mul_b = MW'(sum_abs);
            end
            S_THR0:
            begin
                mul_a = MW'(tol_reg);
                mul_b = root_reg[MW-1:0];
            end
            S_LSEL:
            begin
                mul_a = MW'(nm_reg);
                mul_b = MW'(nm_reg - CW'(1));
            end
            S_LSQ0:
            begin
                mul_a = MW'(log_y_reg);
                mul_b = MW'(log_y_reg);
            end
            S_LN0:
            begin
                mul_a = MW'(diff_reg);
                mul_b = MW'(see_pkg::LN2_Q30);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        embed_next     = embed_reg;
        tol_next       = tol_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        sq_next        = sq_reg;
        sq_pend_next   = 1'b0;
        q_next         = q_reg;
        m_next         = m_reg;
        nm_next        = nm_reg;
        itc_next       = itc_reg;
        acc_next       = acc_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        rad_next       = rad_reg;
        root_next      = root_reg;
        sqbit_next     = sqbit_reg;
        thr_next       = thr_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        cnt_a_next     = cnt_a_reg;
        cnt_b_next     = cnt_b_reg;
        degen_next     = degen_reg;
        short_next     = short_reg;
        log_x_next     = log_x_reg;
        log_e_next     = log_e_reg;
        log_y_next     = log_y_reg;
        frac_next      = frac_reg;
        pass_next      = pass_reg;
        lb_next        = lb_reg;
        diff_next      = diff_reg;
        ent_next       = ent_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                see_pkg::REG_EMBED_DIM:  embed_next = cfg_data[DW-1:0];
                see_pkg::REG_TOL_FACTOR: tol_next   = cfg_data[see_pkg::TOL_W-1:0];
                default: ;
            endcase
        end

        // sum of squares is accumulated in the cycle after the sample is stored
        if (sq_pend_reg)
        begin
            q_next = q_reg + see_pkg::Q_W'(sq_reg);
        end

        case (state_reg)
            S_LOAD:
            begin
                if (in_beat)
                begin
                    if (store_ok)
                    begin
                        count_next   = count_reg + CW'(1);
                        sum_next     = sum_reg + see_pkg::SUM_W'(sample_data.sample);
                        sq_next      = sq_full[see_pkg::SQ_W-1:0];
                        sq_pend_next = 1'b1;
                    end
                    if (sample_data.last)
                    begin
                        state_next = S_SQWAIT;
                    end
                end
            end
            S_SQWAIT:
            begin
                m_next     = m_clamp;
                nm_next    = count_reg - CW'(m_clamp);
                cnt_a_next = '0;
                cnt_b_next = '0;
                degen_next = 1'b0;
                ent_next   = '0;
                if (count_reg <= CW'(m_clamp) + CW'(1))
                begin
                    short_next = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    short_next = 1'b0;
                    state_next = S_MUL0;
                end
            end
            S_MUL0:
            begin
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                acc_next   = prod_reg[see_pkg::V_W-1:0];
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                acc_next   = acc_reg + {prod_reg[see_pkg::V_W-see_pkg::Q_LO_W-1:0],
                                        {see_pkg::Q_LO_W{1'b0}}};
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                // n*Q - S*S, floored at zero
                if (acc_reg >= prod_reg[see_pkg::V_W-1:0])
                begin
                    quo_next = DVW'(acc_reg - prod_reg[see_pkg::V_W-1:0]);
                end
                else
                begin
                    quo_next = '0;
                end
                rem_next   = '0;
                itc_next   = '0;
                state_next = S_DIV1;
            end
            S_DIV1:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                itc_next = itc_reg + see_pkg::ITC_W'(1);
                if (itc_reg == DIV_LAST)
                begin
                    quo_next   = {quo_step[DVW-17:0], 16'b0};
                    rem_next   = '0;
                    itc_next   = '0;
                    state_next = S_DIV2;
                end
            end
            S_DIV2:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                itc_next = itc_reg + see_pkg::ITC_W'(1);
                if (itc_reg == DIV_LAST)
                begin
                    rad_next   = quo_step[RW-1:0];
                    root_next  = '0;
                    sqbit_next = RW'(1) << (RW - 2);
                    itc_next   = '0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (root_ge)
                begin
                    rad_next = rad_reg - root_sum;
                end
                root_next  = root_step;
                sqbit_next = sqbit_reg >> 2;
                itc_next   = itc_reg + see_pkg::ITC_W'(1);
                if (itc_reg == SQRT_LAST)
                begin
                    state_next = S_THR0;
                end
            end
            S_THR0:
            begin
                state_next = S_THR1;
            end
            S_THR1:
            begin
                thr_next   = prod_reg[see_pkg::THR_W-1:0];
                i_next     = '0;
                j_next     = AW'(1);
                k_next     = '0;
                state_next = S_MRD;
            end
            S_MRD:
            begin
                state_next = S_MCMP;
            end
            S_MCMP:
            begin
                state_next = S_MRD;
                if (sample_match && (k_reg < m_reg))
                begin
                    if (k_reg == m_reg - DW'(1))
                    begin
                        if (cnt_b_reg != see_pkg::COUNT_MAX)
                        begin
                            cnt_b_next = cnt_b_reg + see_pkg::COUNT_W'(1);
                        end
                    end
                    k_next = k_reg + DW'(1);
                end
                else
                begin
                    // extra sample check, or template mismatch: next pair
                    if (sample_match && (cnt_a_reg != see_pkg::COUNT_MAX))
                    begin
                        cnt_a_next = cnt_a_reg + see_pkg::COUNT_W'(1);
                    end
                    k_next = '0;
                    if (({1'b0, j_reg} + CW'(1)) < nm_reg)
                    begin
                        j_next = j_reg + AW'(1);
                    end
                    else if (({1'b0, i_reg} + CW'(2)) < nm_reg)
                    begin
                        i_next = i_reg + AW'(1);
                        j_next = i_reg + AW'(2);
                    end
                    else
                    begin
                        state_next = S_LSEL;
                    end
                end
            end
            S_LSEL:
            begin
                pass_next = 1'b0;
                log_e_next = see_pkg::LOG_E_W'(LW - 1);
                if ((cnt_a_reg == '0) || (cnt_b_reg == '0))
                begin
                    degen_next = 1'b1;
                    state_next = S_LDEG;
                end
                else
                begin
                    degen_next = 1'b0;
                    log_x_next = LW'(cnt_b_reg);
                    state_next = S_LNORM;
                end
            end
            S_LDEG:
            begin
                log_x_next = prod_reg[LW-1:0];
                state_next = S_LNORM;
            end
            S_LNORM:
            begin
                // one position a cycle until the top bit lands in the msb
                if (log_x_reg[LW-1])
                begin
                    log_y_next = log_x_reg[LW-1:1];
                    frac_next  = '0;
                    itc_next   = '0;
                    state_next = S_LSQ0;
                end
                else
                begin
                    log_x_next = log_x_reg << 1;
                    log_e_next = log_e_reg - see_pkg::LOG_E_W'(1);
                end
            end
            S_LSQ0:
            begin
                state_next = S_LSQ1;
            end
            S_LSQ1:
            begin
                if (sq_t[31])
                begin
                    log_y_next = sq_t[31:1];
                end
                else
                begin
                    log_y_next = sq_t[30:0];
                end
                frac_next = {frac_reg[see_pkg::LOG_F_W-2:0], sq_t[31]};
                itc_next  = itc_reg + see_pkg::ITC_W'(1);
                if (itc_reg == LSQ_LAST)
                begin
                    state_next = S_LDONE;
                end
                else
                begin
                    state_next = S_LSQ0;
                end
            end
            S_LDONE:
            begin
                if (degen_reg)
                begin
                    diff_next  = l2_val;
                    state_next = S_LN0;
                end
                else if (!pass_reg)
                begin
                    lb_next    = l2_val;
                    log_x_next = LW'(cnt_a_reg);
                    log_e_next = see_pkg::LOG_E_W'(LW - 1);
                    pass_next  = 1'b1;
                    state_next = S_LNORM;
                end
                else
                begin
                    diff_next  = (lb_reg > l2_val) ? lb_reg - l2_val : '0;
                    state_next = S_LN0;
                end
            end
            S_LN0:
            begin
                state_next = S_LN1;
            end
            S_LN1:
            begin
                if (ln_sum[51:35] > 17'd65535)
                begin
                    ent_next = {see_pkg::ENT_W{1'b1}};
                end
                else
                begin
                    ent_next = ln_sum[50:35];
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next                 = 1'b1;
                    out_data_next.match_count_next = cnt_a_reg;
                    out_data_next.match_count_base = cnt_b_reg;
                    out_data_next.entropy          = ent_reg;
                    out_data_next.degenerate       = degen_reg;
                    out_data_next.too_short        = short_reg;
                    count_next                     = '0;
                    sum_next                       = '0;
                    q_next                         = '0;
                    state_next                     = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            embed_reg     <= see_pkg::DIM_RESET;
            tol_reg       <= see_pkg::TOL_RESET;
            count_reg     <= '0;
            sum_reg       <= '0;
            sq_pend_reg   <= 1'b0;
            q_reg         <= '0;
            itc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            embed_reg     <= embed_next;
            tol_reg       <= tol_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            sq_pend_reg   <= sq_pend_next;
            q_reg         <= q_next;
            itc_reg       <= itc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        sq_reg       <= sq_next;
        m_reg        <= m_next;
        nm_reg       <= nm_next;
        acc_reg      <= acc_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        rad_reg      <= rad_next;
        root_reg     <= root_next;
        sqbit_reg    <= sqbit_next;
        thr_reg      <= thr_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        cnt_a_reg    <= cnt_a_next;
        cnt_b_reg    <= cnt_b_next;
        degen_reg    <= degen_next;
        short_reg    <= short_next;
        log_x_reg    <= log_x_next;
        log_e_reg    <= log_e_next;
        log_y_reg    <= log_y_next;
        frac_reg     <= frac_next;
        pass_reg     <= pass_next;
        lb_reg       <= lb_next;
        diff_reg     <= diff_next;
        ent_reg      <= ent_next;
        out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_data.too_short) |->
            (result_data.match_count_next == '0) && (result_data.match_count_base == '0)
            && (result_data.entropy == '0) && !result_data.degenerate)
        else $error("too_short beat carries nonzero fields");

    a_a_le_b: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_data.match_count_next <= result_data.match_count_base))
        else $error("count A exceeds count B");

    a_degen_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_data.too_short) |->
            (result_data.degenerate == ((result_data.match_count_next == '0)
                                        || (result_data.match_count_base == '0))))
        else $error("degenerate flag disagrees with counts");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MRD) |-> (j_reg > i_reg) && ({1'b0, j_reg} < nm_reg))
        else $error("pair indices out of order");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(see_pkg::MAX_SAMPLES))
        else $error("sample count past store depth");
`endif

endmodule
`default_nettype wire

// File: bench/sample_entropy_engine_tb.sv
// self-checking testbench for the sample entropy engine
module sample_entropy_engine_tb;

    localparam longint unsigned CYCLE_LIMIT = 64'd80_000_000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sample_valid = 1'b0;
    logic sample_stall;
    see_pkg::see_in_t sample_data = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    see_pkg::see_out_t result_data;
    logic cfg_we = 1'b0;
    logic [see_pkg::CFG_IDX_W-1:0] cfg_index = see_pkg::REG_EMBED_DIM;
    logic [see_pkg::CFG_W-1:0] cfg_data = '0;

    sample_entropy_engine DUT (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_valid), .sample_stall(sample_stall), .sample_data(sample_data),
        .result_valid(result_valid), .result_stall(result_stall), .result_data(result_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // beats waiting to be offered, and entropy results still owed by the block
    see_pkg::see_in_t  beat_feed[$];
    see_pkg::see_out_t owed_results[$];

    // shadow of the block: registers, sample memory, running totals
    logic [3:0] dim_shadow = 4'd2;
    logic [7:0] tol_shadow = 8'd51;
    logic signed [15:0] series_mem [0:see_pkg::MAX_SAMPLES-1];
    int unsigned series_len = 0;
    longint series_sum = 0;

    int errors = 0;
    int beats_taken = 0;
    int series_done = 0;
    int short_seen = 0;
    int degen_seen = 0;
    int hold_requests = 0;
    int holds_done = 0;
    longint unsigned cycles = 0;
    bit took = 1'b0;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // log2 in Q.16 by repeated squaring of the normalized mantissa
    function automatic longint unsigned log2_fix(longint unsigned v);
        int unsigned e;
        longint unsigned y, frac;
        e = 0;
        frac = 0;
        while (e < 63 && (v >> (e + 1)) != 0)
            e++;
        y = (e <= 30) ? (v << (30 - e)) : (v >> (e - 30));
        for (int n = 0; n < 16; n++)
        begin
            y = (y * y) >> 30;
            frac <<= 1;
            if (y >= (64'd1 << 31))
            begin
                y >>= 1;
                frac |= 1;
            end
        end
        return (longint'(e) << 16) | frac;
    endfunction

    function automatic longint unsigned ln_q11(longint unsigned l2);
        longint unsigned r;
        r = (l2 * longint'(see_pkg::LN2_Q30) + (64'd1 << 34)) >> 35;
        return (r > 65535) ? 65535 : r;
    endfunction

    function automatic bit within_tol(int a, int b, longint unsigned thr);
        longint unsigned ad;
        ad = (a > b) ? a - b : b - a;
        return (ad << 16) <= thr;
    endfunction

    // entropy of the series now held in series_mem
    function automatic see_pkg::see_out_t series_entropy();
        see_pkg::see_out_t r;
        int unsigned n, m, nm, k;
        longint unsigned q, v, sabs, sd, thr, cnt_a, cnt_b, la, lb, ent;
        r = '0;
        n = series_len;
        m = (dim_shadow == 0) ? 1
          : (dim_shadow > see_pkg::MAX_DIM) ? see_pkg::MAX_DIM : dim_shadow;
        if (n <= m + 1)
        begin
            r.too_short = 1'b1;
            return r;
        end
        q = 0;
        for (int i = 0; i < n; i++)
            q += longint'(series_mem[i]) * longint'(series_mem[i]);
        sabs = (series_sum < 0) ? -series_sum : series_sum;
        v = longint'(n) * q;
        v = (v >= sabs * sabs) ? v - sabs * sabs : 0;
        sd = int_sqrt(((v / n) << 16) / n);
        thr = longint'(tol_shadow) * sd;
        nm = n - m;
        cnt_a = 0;
        cnt_b = 0;
        for (int i = 0; i < nm; i++)
            for (int j = i + 1; j < nm; j++)
            begin
                for (k = 0; k < m; k++)
                    if (!within_tol(series_mem[i+k], series_mem[j+k], thr))
                        break;
                if (k == m)
                begin
                    cnt_b++;
                    if (within_tol(series_mem[i+m], series_mem[j+m], thr))
                        cnt_a++;
                end
            end
        r.degenerate = (cnt_a == 0 || cnt_b == 0);
        if (r.degenerate)
            ent = ln_q11(log2_fix(longint'(nm) * longint'(nm - 1)));
        else
        begin
            la = log2_fix(cnt_a);
            lb = log2_fix(cnt_b);
            ent = ln_q11((lb > la) ? lb - la : 0);
        end
        r.match_count_next = (cnt_a > see_pkg::COUNT_MAX) ? see_pkg::COUNT_MAX : cnt_a;
        r.match_count_base = (cnt_b > see_pkg::COUNT_MAX) ? see_pkg::COUNT_MAX : cnt_b;
        r.entropy = ent[15:0];
        return r;
    endfunction

    // rising edge: track accepted beats, register writes, and check results
    always @(posedge clk)
    begin
        see_pkg::see_out_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("sample_entropy_engine_tb: errors");
            $finish;
        end
        took = rst_n && sample_valid && !sample_stall;
        if (rst_n && cfg_we)
        begin
            if (cfg_index == see_pkg::REG_EMBED_DIM)
                dim_shadow = cfg_data[3:0];
            else if (cfg_index == see_pkg::REG_TOL_FACTOR)
                tol_shadow = cfg_data;
        end
        if (took)
        begin
            beats_taken++;
            if (series_len < see_pkg::MAX_SAMPLES)
            begin
                series_mem[series_len] = sample_data.sample;
                series_len++;
                series_sum += sample_data.sample;
            end
            if (sample_data.last)
            begin
                owed_results.push_back(series_entropy());
                series_len = 0;
                series_sum = 0;
            end
        end
        if (rst_n && result_valid && !result_stall)
        begin
            if (owed_results.size() == 0)
            begin
                $error("result with nothing owed");
                errors++;
            end
            else
            begin
                want = owed_results.pop_front();
                series_done++;
                short_seen += want.too_short;
                degen_seen += want.degenerate;
                if (result_data.match_count_next !== want.match_count_next)
                begin
                    $error("match_count_next exp %0d got %0d",
                           want.match_count_next, result_data.match_count_next);
                    errors++;
                end
                if (result_data.match_count_base !== want.match_count_base)
                begin
                    $error("match_count_base exp %0d got %0d",
                           want.match_count_base, result_data.match_count_base);
                    errors++;
                end
                if (result_data.entropy !== want.entropy)
                begin
                    $error("entropy exp %0d got %0d", want.entropy, result_data.entropy);
                    errors++;
                end
                if (result_data.degenerate !== want.degenerate)
                begin
                    $error("degenerate exp %0d got %0d", want.degenerate, result_data.degenerate);
                    errors++;
                end
                if (result_data.too_short !== want.too_short)
                begin
                    $error("too_short exp %0d got %0d", want.too_short, result_data.too_short);
                    errors++;
                end
            end
        end
    end

    // sample driver: bursts of beats with random gaps between them
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge clk)
    begin
        if (rst_n && (!sample_valid || took))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                sample_valid <= 1'b0;
            end
            else if (beat_feed.size() > 0)
            begin
                sample_data <= beat_feed.pop_front();
                sample_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                sample_valid <= 1'b0;
        end
    end

    // result receiver: own stall pattern, plus long hold-offs on request
    int hold_left = 0;
    int stall_mode = 0;
    int mode_left = 0;
    always @(negedge clk)
    begin
        logic st;
        st = 1'b0;
        if (rst_n)
        begin
            if (hold_requests != holds_done && hold_left == 0)
            begin
                holds_done++;
                hold_left = 3000;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                st = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 400);
                end
                mode_left--;
                case (stall_mode)
                    1: st = $urandom_range(0, 1);
                    2: st = ($urandom_range(0, 7) != 0);
                    default: st = 1'b0;
                endcase
            end
            result_stall <= st;
        end
    end

    // wait until every beat is taken and every result has come back
    task automatic drain();
        while (beat_feed.size() != 0 || sample_valid || owed_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic [see_pkg::CFG_IDX_W-1:0] idx,
                             logic [see_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_regs(logic [see_pkg::CFG_W-1:0] dim, logic [see_pkg::CFG_W-1:0] tol);
        drain();
        write_reg(see_pkg::REG_EMBED_DIM, dim);
        write_reg(see_pkg::REG_TOL_FACTOR, tol);
    endtask

    // one series: kind picks the flavor of content
    task automatic queue_series(int len, int kind);
        see_pkg::see_in_t b;
        int base;
        base = $urandom_range(0, 65535) - 32768;
        for (int i = 0; i < len; i++)
        begin
            case (kind)
                0: b.sample = $urandom_range(0, 65535);
                1: b.sample = 16'(base / 2 + $urandom_range(0, 6) - 3);
                2: b.sample = 16'(base);
                3: b.sample = 16'(i * 64 + $urandom_range(0, 127));
                default: b.sample = 16'(i);
            endcase
            b.last = (i == len - 1);
            beat_feed.push_back(b);
        end
    endtask

    task automatic queue_list(int vals[$]);
        see_pkg::see_in_t b;
        foreach (vals[i])
        begin
            b.sample = 16'(vals[i]);
            b.last = (i == vals.size() - 1);
            beat_feed.push_back(b);
        end
    endtask

    initial
    begin
        int len, kind, dims[$], tols[$];
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings, short series, extremes, flat series
        queue_list('{-32768});
        queue_list('{1, 2, 3});
        queue_list('{32767, -32768, 32767, -32768});
        queue_series(6, 2);
        queue_series(10, 1);
        set_regs(8'hF0, 8'd255);
        queue_list('{5, 5, 6});
        set_regs(8'h0F, 8'd0);
        queue_series(9, 1);
        queue_series(10, 1);
        set_regs(8'd8, 8'd128);
        queue_series(20, 1);
        set_regs(8'd1, 8'd0);
        queue_series(24, 4);

        // random phases over a spread of settings
        dims = '{1, 2, 3, 4, 8, 0, 12, 2};
        tols = '{0, 51, 255, 128, 20, 200, 77, 51};
        for (int p = 0; p < 20; p++)
        begin
            if (p < dims.size())
                set_regs(8'(dims[p]), 8'(tols[p]));
            else
                set_regs($urandom_range(0, 255), $urandom_range(0, 255));
            if (p == 5)
                hold_requests++;
            for (int s = 0; s < 8; s++)
            begin
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 14);
                kind = $urandom_range(0, 3);
                queue_series(len, kind);
            end
        end
        drain();
        repeat (200) @(posedge clk);
        $display("covered %0d beats in %0d series (%0d too short, %0d degenerate)",
                 beats_taken, series_done, short_seen, degen_seen);
        $display("settings swept over template lengths 0..15 and tolerances 0..255");
        if (errors == 0)
            $display("sample_entropy_engine_tb: clean");
        else
            $display("sample_entropy_engine_tb: errors");
        $finish;
    end
endmodule

// File: sample_entropy_engine.f
hw/rtl/see_pkg.sv
hw/rtl/see_ram.sv
hw/rtl/sample_entropy_engine.sv
bench/sample_entropy_engine_tb.sv
